>>> hw/rtl/bfkr_pkg.sv
`timescale 1ns / 1ps

package bfkr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int TAG_W     = 16;
    localparam int LEN_W     = 7;
    localparam int CFG_W     = 7;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

    typedef enum logic [1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_DEQ   = 2'd1,
        FUNC_REM   = 2'd2,
        FUNC_QUERY = 2'd3
    } bfkr_func_t;

    // register index on the configuration port (paddr[2])
    typedef enum logic {
        REG_MAX_ENTRIES = 1'b0,
        REG_NONE        = 1'b1
    } bfkr_reg_t;

    // command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
    } bfkr_cmd_t;

endpackage

>>> hw/rtl/bfkr_if.sv
`timescale 1ns / 1ps

interface bfkr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] item_tag;

    modport source (output valid, output func, output item_tag, input ready);
    modport sink   (input valid, input func, input item_tag, output ready);
endinterface

interface bfkr_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] head_tag;
    logic        head_valid;
    logic [6:0]  length;
    logic        full_res;
    logic        empty_res;

    modport source (output valid, output status, output head_tag, output head_valid,
                    output length, output full_res, output empty_res, input ready);
    modport sink   (input valid, input status, input head_tag, input head_valid,
                    input length, input full_res, input empty_res, output ready);
endinterface

>>> hw/rtl/bfkr_cell.sv
`timescale 1ns / 1ps

module bfkr_cell
    import bfkr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bfkr_cmd_t        cmd,
    input  logic [TAG_W-1:0] key,
    input  logic             prev_valid,
    input  logic [TAG_W-1:0] next_tag,
    input  logic             next_valid,
    input  logic             seen_in,
    output logic             seen_out,
    output logic [TAG_W-1:0] tag,
    output logic             valid
);

    logic [TAG_W-1:0] tag_reg;
    logic             valid_reg;
    logic             match;
    logic             shift;
    logic             load;

    assign match    = valid_reg && (tag_reg == key);
    assign seen_out = seen_in | match;
    // move up from the neighbor behind: whole queue on dequeue, from first match on remove
    assign shift    = cmd.deq | (cmd.rem & seen_out);
    // first free place takes the new tag
    assign load     = cmd.enq & ~valid_reg & prev_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= next_valid;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tag_reg <= next_tag;
        end
        else if (load)
        begin
            tag_reg <= key;
        end
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;

endmodule

>>> hw/rtl/bounded_fifo_with_keyed_remove.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                                                  | Item
// req     | in  | func, item_tag                                           | one request
// rsp     | out | status, head_tag, head_valid, length, full_res, empty_res | one result
// apb     | in  | max_entries at byte address 0                            | register write
//
// Every request, remove included, is taken at one item per cycle while rsp is not held back.
// The first-match search ripples through the row of cells in the cycle the remove is taken.
// Reset clears all cell valid bits, the length and the result valid bit.
// req is taken whenever the result register is empty or being drained.

module bounded_fifo_with_keyed_remove
    import bfkr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    bfkr_req_if.sink          req,
    bfkr_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0] max_entries_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             rsp_valid_reg;
    logic             status_reg;
    logic             status_next;

    logic             accept;
    bfkr_func_t       func;
    bfkr_cmd_t        cmd;
    logic             full;
    logic             found;
    logic [LW-1:0]    limit;

    logic [TAG_W-1:0] tag_w   [DEPTH];
    logic             valid_w [DEPTH];
    logic             seen_w  [DEPTH+1];

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (psel && penable && pwrite && (bfkr_reg_t'(paddr[2]) == REG_MAX_ENTRIES))
        begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (bfkr_reg_t'(paddr[2]) == REG_MAX_ENTRIES)
        begin
            prdata = APB_DW'(max_entries_reg);
        end
    end

    // limit is the smaller of max_entries and DEPTH
    assign limit = (LW'(max_entries_reg) < LW'(DEPTH)) ? LW'(max_entries_reg) : LW'(DEPTH);
    assign full  = LW'(count_reg) >= limit;

    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;
    assign func      = bfkr_func_t'(req.func);

    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            unique case (func)
                FUNC_ENQ:   cmd.enq = ~full;
                FUNC_DEQ:   cmd.deq = (count_reg != '0);
                FUNC_REM:   cmd.rem = 1'b1;
                FUNC_QUERY: cmd = '0;
                default:    cmd = '0;
            endcase
        end
    end

    // row of cells, head at index 0
    assign seen_w[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             prev_valid;
        logic [TAG_W-1:0] next_tag;
        logic             next_valid;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_tag   = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_tag   = tag_w[i+1];
            assign next_valid = valid_w[i+1];
        end

        bfkr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .key        (req.item_tag),
            .prev_valid (prev_valid),
            .next_tag   (next_tag),
            .next_valid (next_valid),
            .seen_in    (seen_w[i]),
            .seen_out   (seen_w[i+1]),
            .tag        (tag_w[i]),
            .valid      (valid_w[i])
        );
    end

    assign found = seen_w[DEPTH];

    always_comb
    begin
        count_next  = count_reg;
        status_next = 1'b0;
        unique case (func)
            FUNC_ENQ:
            begin
                status_next = full;
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_DEQ:
            begin
                status_next = (count_reg == '0);
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_REM:
            begin
                status_next = ~found;
                if (found)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                status_next = 1'b0;
            end
            default:
            begin
                status_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // queue state only moves on an accept, which also drains the pending result
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.head_valid = valid_w[0];
    assign rsp.head_tag   = valid_w[0] ? tag_w[0] : '0;
    assign rsp.length     = LEN_W'(count_reg);
    assign rsp.full_res   = full;
    assign rsp.empty_res  = (count_reg == '0);

endmodule

>>> tb/bounded_fifo_with_keyed_remove_test.sv
`timescale 1ns / 1ps

module bounded_fifo_with_keyed_remove_test;
    import bfkr_pkg::*;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic             status;
        logic [TAG_W-1:0] head_tag;
        logic             head_valid;
        logic [LEN_W-1:0] length;
        logic             full_res;
        logic             empty_res;
    } fifo_result_t;

    typedef struct packed {
        bfkr_func_t       func;
        logic [TAG_W-1:0] tag;
    } fifo_req_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bfkr_req_if req_ch ();
    bfkr_rsp_if rsp_ch ();

    bounded_fifo_with_keyed_remove dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the queue contents and the limit register
    logic [TAG_W-1:0] stored_tags[$];
    logic [CFG_W-1:0] cur_limit = MAX_ENTRIES_RST;

    fifo_req_t        pending_reqs[$];
    fifo_result_t     expected_results[$];
    logic [TAG_W-1:0] recent_tags[$];
    int               n_sent   = 0;
    int               n_errors = 0;
    int               cycles   = 0;
    logic             calm;

    // one stretch of the run with no gaps on either side
    assign calm = (n_sent >= 700) && (n_sent < 1000);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic fifo_result_t apply_request(bfkr_func_t op, logic [TAG_W-1:0] tag);
        fifo_result_t r;
        int           eff;
        int           hit;
        eff      = (cur_limit > DEPTH_DEF) ? DEPTH_DEF : int'(cur_limit);
        r.status = ST_OK;
        case (op)
            FUNC_ENQ:
            begin
                if (stored_tags.size() >= eff)
                    r.status = ST_ERR;
                else
                    stored_tags.push_back(tag);
            end
            FUNC_DEQ:
            begin
                if (stored_tags.size() == 0)
                    r.status = ST_ERR;
                else
                    void'(stored_tags.pop_front());
            end
            FUNC_REM:
            begin
                hit = -1;
                for (int i = 0; i < stored_tags.size(); i++)
                    if (hit < 0 && stored_tags[i] == tag)
                        hit = i;
                if (hit < 0)
                    r.status = ST_ERR;
                else
                    stored_tags.delete(hit);
            end
            default:
            begin
            end
        endcase
        r.head_valid = (stored_tags.size() > 0);
        r.head_tag   = (stored_tags.size() > 0) ? stored_tags[0] : '0;
        r.length     = LEN_W'(stored_tags.size());
        r.full_res   = (stored_tags.size() >= eff);
        r.empty_res  = (stored_tags.size() == 0);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            n_errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive_blk
        logic      busy;
        fifo_req_t item;
        if (rst_n)
        begin
            busy = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_request(bfkr_func_t'(req_ch.func),
                                                         req_ch.item_tag));
                n_sent++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 24))
                begin
                    item = pending_reqs.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.func     <= item.func;
                    req_ch.item_tag <= item.tag;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : mon_blk
        fifo_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with none expected, got length %0d head %0h",
                             $time, rsp_ch.length, rsp_ch.head_tag);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("head_tag", want.head_tag, rsp_ch.head_tag);
                    check_field("head_valid", want.head_valid, rsp_ch.head_valid);
                    check_field("length", want.length, rsp_ch.length);
                    check_field("full_res", want.full_res, rsp_ch.full_res);
                    check_field("empty_res", want.empty_res, rsp_ch.empty_res);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void push_req(bfkr_func_t op, logic [TAG_W-1:0] tag);
        fifo_req_t item;
        item.func = op;
        item.tag  = tag;
        pending_reqs.push_back(item);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_ENTRIES, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_limit  = value;
    endtask

    // mostly a small tag pool so removes hit and duplicates occur
    task automatic queue_random(input int count, input int enq_pct);
        int               r;
        logic [TAG_W-1:0] tag;
        recent_tags.delete();
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < enq_pct)
            begin
                if ($urandom_range(99) < 15)
                    tag = TAG_W'($urandom());
                else
                    tag = TAG_W'($urandom_range(23));
                recent_tags.push_back(tag);
                if (recent_tags.size() > 64)
                    void'(recent_tags.pop_front());
                push_req(FUNC_ENQ, tag);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 35)
                    push_req(FUNC_DEQ, TAG_W'($urandom()));
                else if (r < 85)
                begin
                    if (recent_tags.size() != 0 && $urandom_range(99) < 75)
                        tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
                    else
                        tag = TAG_W'($urandom());
                    push_req(FUNC_REM, tag);
                end
                else
                    push_req(FUNC_QUERY, TAG_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_QUERY;
        req_ch.item_tag = '0;
        rsp_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue, duplicates, first-match remove, missing tag
        push_req(FUNC_QUERY, 16'h0000);
        push_req(FUNC_DEQ, 16'h0000);
        push_req(FUNC_REM, 16'h0000);
        push_req(FUNC_ENQ, 16'h0000);
        push_req(FUNC_ENQ, 16'hFFFF);
        push_req(FUNC_ENQ, 16'hFFFF);
        push_req(FUNC_ENQ, 16'h1234);
        push_req(FUNC_REM, 16'hFFFF);
        push_req(FUNC_REM, 16'hBEEF);
        push_req(FUNC_QUERY, 16'hFFFF);
        push_req(FUNC_DEQ, 16'hFFFF);
        push_req(FUNC_DEQ, 16'h0000);
        push_req(FUNC_DEQ, 16'h0000);
        push_req(FUNC_DEQ, 16'h0000);

        // zero limit rejects every enqueue
        set_limit(7'd0);
        push_req(FUNC_ENQ, 16'h5555);
        push_req(FUNC_QUERY, 16'h0000);

        // fill to a small limit, then lower it below the length
        set_limit(7'd2);
        push_req(FUNC_ENQ, 16'hAAAA);
        push_req(FUNC_ENQ, 16'h5555);
        push_req(FUNC_ENQ, 16'h0001);
        set_limit(7'd1);
        push_req(FUNC_ENQ, 16'h0002);
        push_req(FUNC_DEQ, 16'h0000);
        push_req(FUNC_ENQ, 16'h0003);
        push_req(FUNC_DEQ, 16'h0000);
        push_req(FUNC_ENQ, 16'h0004);

        // limit above the store depth acts as the depth
        set_limit(7'd127);
        queue_random(300, 62);
        set_limit(7'd64);
        queue_random(250, 45);
        set_limit(7'd8);
        queue_random(250, 50);
        set_limit(7'd1);
        queue_random(150, 50);
        set_limit(7'd0);
        queue_random(80, 40);
        set_limit(7'd3);
        queue_random(200, 50);
        set_limit(7'd64);
        queue_random(420, 56);

        wait_idle();
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> bounded_fifo_with_keyed_remove.f
hw/rtl/bfkr_pkg.sv
hw/rtl/bfkr_if.sv
hw/rtl/bfkr_cell.sv
hw/rtl/bounded_fifo_with_keyed_remove.sv
tb/bounded_fifo_with_keyed_remove_test.sv
